// ===== src/dcg_pkg.sv =====
`timescale 1ns / 1ps

package dcg_pkg;

  // Sector count after clamping fits in 28 bits.
  localparam int unsigned TotalWidth = 28;
  localparam int unsigned CthWidth   = 20;

  localparam logic [TotalWidth-1:0] MAX_SECTORS = 28'd267382800;  // 65535*16*255
  localparam logic [TotalWidth-1:0] BIG_SECTORS = 28'd66059280;   // 65535*16*63

  localparam logic [7:0] SPT_17  = 8'd17;
  localparam logic [7:0] SPT_31  = 8'd31;
  localparam logic [7:0] SPT_63  = 8'd63;
  localparam logic [7:0] SPT_255 = 8'd255;

  localparam logic [4:0] HEADS_MIN = 5'd4;
  localparam logic [4:0] HEADS_MAX = 5'd16;

  // Reciprocals ceil(2^S / d); exact floor division for any 28-bit dividend.
  localparam int unsigned RecipWidth = 29;
  localparam logic [RecipWidth-1:0] RECIP_17  = 29'd505290271;  // S = 33
  localparam logic [RecipWidth-1:0] RECIP_31  = 29'd277094665;  // S = 33
  localparam logic [RecipWidth-1:0] RECIP_63  = 29'd272696337;  // S = 34
  localparam logic [RecipWidth-1:0] RECIP_255 = 29'd269488145;  // S = 36

  // Reciprocal ceil(2^19 / h) for head counts 4..15, exact for dividends below 2^14.
  localparam int unsigned HeadRecipWidth = 18;
  localparam int unsigned HeadShift      = 19;

  function automatic logic [HeadRecipWidth-1:0] head_recip(input logic [4:0] heads);
    logic [HeadRecipWidth-1:0] r;
    unique case (heads)
      5'd4:    r = 18'd131072;
      5'd5:    r = 18'd104858;
      5'd6:    r = 18'd87382;
      5'd7:    r = 18'd74899;
      5'd8:    r = 18'd65536;
      5'd9:    r = 18'd58255;
      5'd10:   r = 18'd52429;
      5'd11:   r = 18'd47663;
      5'd12:   r = 18'd43691;
      5'd13:   r = 18'd40330;
      5'd14:   r = 18'd37450;
      5'd15:   r = 18'd34953;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [7:0]          spt;
    logic [4:0]          heads;
    logic [CthWidth-1:0] cth;
  } dcg_chs_t;

endpackage

// ===== src/disk_chs_geometry_core.sv =====
`timescale 1ns / 1ps

// Converts a disk size in bytes into the cylinder/head/sector geometry of a
// virtual-disk footer. One item is taken every cycle unless the output stalls.
// The seven register stages are clamping, the divisions by 17 (or 255), 31 and
// 63 done as reciprocal multiplies one after another so each sector choice can
// see the previous one, the final sector choice, the reciprocal multiply that
// divides by fewer than 16 heads, and the output register. Stall back-pressure
// fills bubbles stage by stage, so an idle stage never holds up the input.
module disk_chs_geometry_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] disk_size_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] geometry_word,
  output logic [15:0] cylinder_count,
  output logic [4:0]  head_count,
  output logic [7:0]  sectors_per_track
);
  import dcg_pkg::*;

  logic     mid_valid;
  logic     mid_stall;
  dcg_chs_t mid_chs;

  dcg_sector_search u_search (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (in_valid),
    .up_stall        (in_stall),
    .disk_size_bytes (disk_size_bytes),
    .dn_valid        (mid_valid),
    .dn_stall        (mid_stall),
    .dn_chs          (mid_chs)
  );

  dcg_cyl_div u_cyl (
    .clk               (clk),
    .rst               (rst),
    .up_valid          (mid_valid),
    .up_stall          (mid_stall),
    .up_chs            (mid_chs),
    .dn_valid          (out_valid),
    .dn_stall          (out_stall),
    .geometry_word     (geometry_word),
    .cylinder_count    (cylinder_count),
    .head_count        (head_count),
    .sectors_per_track (sectors_per_track)
  );

endmodule

// ===== src/dcg_sector_search.sv =====
`timescale 1ns / 1ps

module dcg_sector_search (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_stall,
  input  logic [47:0]      disk_size_bytes,
  output logic             dn_valid,
  input  logic             dn_stall,
  output dcg_pkg::dcg_chs_t dn_chs
);
  import dcg_pkg::*;

  localparam int unsigned NumStages = 5;
  localparam int unsigned ProdWidth = TotalWidth + RecipWidth;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] adv;

  // Stage 1: sector count, clamp
  logic [38:0]           sectors_raw;
  logic [TotalWidth-1:0] total_clamped;
  logic [TotalWidth-1:0] t1;
  logic                  big1;

  // Stage 2: divide by 17 (or 255 for large disks)
  logic [ProdWidth-1:0]  p2;
  logic [TotalWidth-1:0] t2;
  logic                  big2;

  // Stage 3: head estimate at 17 sectors, divide by 31
  logic [23:0]           cth_a;
  logic [24:0]           cth_round;
  logic [14:0]           heads_raw;
  logic [14:0]           heads_est;
  logic                  fail17;
  logic [ProdWidth-1:0]  p31;
  logic [23:0]           cth3;
  logic [4:0]            heads3;
  logic [7:0]            spt3;
  logic                  use31_3;
  logic [23:0]           q31_3;
  logic [TotalWidth-1:0] t3;

  // Stage 4: check 31 sectors, divide by 63
  logic [ProdWidth-1:0]  p63;
  logic                  fail31;
  logic [23:0]           cth4;
  logic [4:0]            heads4;
  logic [7:0]            spt4;
  logic                  use63_4;
  logic [22:0]           q63_4;

  // Stage 5: final choice
  dcg_chs_t              chs5;

  always_comb begin
    adv[NumStages-1] = !vld[NumStages-1] || !dn_stall;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign up_stall = !adv[0];
  assign dn_valid = vld[NumStages-1];
  assign dn_chs   = chs5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= up_valid;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1
  always_comb begin
    sectors_raw   = disk_size_bytes[47:9];
    total_clamped = (sectors_raw > {11'd0, MAX_SECTORS}) ? MAX_SECTORS
                                                          : sectors_raw[TotalWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t1   <= total_clamped;
      big1 <= (total_clamped >= BIG_SECTORS);
    end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p2   <= {{RecipWidth{1'b0}}, t1} * {{TotalWidth{1'b0}}, (big1 ? RECIP_255 : RECIP_17)};
      t2   <= t1;
      big2 <= big1;
    end
  end

  // Stage 3
  always_comb begin
    cth_a     = big2 ? {3'd0, p2[ProdWidth-1:36]} : p2[ProdWidth-1:33];
    cth_round = {1'b0, cth_a} + 25'd1023;
    heads_raw = cth_round[24:10];
    heads_est = (heads_raw < 15'd4) ? 15'd4 : heads_raw;
    fail17    = !big2 && (({1'b0, cth_a} >= {heads_est, 10'd0})
                          || (heads_est > 15'd16));
    p31       = {{RecipWidth{1'b0}}, t2} * {{TotalWidth{1'b0}}, RECIP_31};
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cth3    <= cth_a;
      heads3  <= big2 ? HEADS_MAX : heads_est[4:0];
      spt3    <= big2 ? SPT_255 : SPT_17;
      use31_3 <= fail17;
      q31_3   <= p31[ProdWidth-1:33];
      t3      <= t2;
    end
  end

  // Stage 4
  always_comb begin
    fail31 = use31_3 && (q31_3 >= 24'd16384);
    p63    = {{RecipWidth{1'b0}}, t3} * {{TotalWidth{1'b0}}, RECIP_63};
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      cth4    <= use31_3 ? q31_3 : cth3;
      heads4  <= use31_3 ? HEADS_MAX : heads3;
      spt4    <= use31_3 ? SPT_31 : spt3;
      use63_4 <= fail31;
      q63_4   <= p63[ProdWidth-1:34];
    end
  end

  // Stage 5
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      chs5.cth   <= use63_4 ? q63_4[CthWidth-1:0] : cth4[CthWidth-1:0];
      chs5.heads <= use63_4 ? HEADS_MAX : heads4;
      chs5.spt   <= use63_4 ? SPT_63 : spt4;
    end
  end

endmodule

// ===== src/dcg_cyl_div.sv =====
`timescale 1ns / 1ps

module dcg_cyl_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_stall,
  input  dcg_pkg::dcg_chs_t up_chs,
  output logic              dn_valid,
  input  logic              dn_stall,
  output logic [31:0]       geometry_word,
  output logic [15:0]       cylinder_count,
  output logic [4:0]        head_count,
  output logic [7:0]        sectors_per_track
);
  import dcg_pkg::*;

  localparam int unsigned ProdWidth = 14 + HeadRecipWidth;

  logic [1:0]           vld;
  logic [1:0]           adv;
  logic [ProdWidth-1:0] prod6;
  dcg_chs_t             chs6;
  logic [15:0]          cyl;

  assign adv[1]   = !vld[1] || !dn_stall;
  assign adv[0]   = !vld[0] || adv[1];
  assign up_stall = !adv[0];
  assign dn_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= up_valid;
      if (adv[1]) vld[1] <= vld[0];
    end
  end

  // Fewer than 16 heads only with 17 sectors, where the dividend stays below 2^14.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod6 <= {{HeadRecipWidth{1'b0}}, up_chs.cth[13:0]}
               * {14'd0, head_recip(up_chs.heads)};
      chs6  <= up_chs;
    end
  end

  always_comb begin
    if (chs6.heads == HEADS_MAX) begin
      cyl = chs6.cth[CthWidth-1:4];
    end else begin
      cyl = {3'd0, prod6[ProdWidth-1:HeadShift]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      geometry_word     <= {cyl, 3'd0, chs6.heads, chs6.spt};
      cylinder_count    <= cyl;
      head_count        <= chs6.heads;
      sectors_per_track <= chs6.spt;
    end
  end

endmodule

// ===== src/dcg_checker.sv =====
`timescale 1ns / 1ps

module dcg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] geometry_word,
  input logic [15:0] cylinder_count,
  input logic [4:0]  head_count,
  input logic [7:0]  sectors_per_track
);

  // A stalled item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(geometry_word))
    else $error("output item changed while stalled");

  a_word_packing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> geometry_word[31:16] == cylinder_count
               && geometry_word[15:8] == {3'd0, head_count}
               && geometry_word[7:0] == sectors_per_track)
    else $error("geometry word does not match the separate fields");

  a_spt_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sectors_per_track == 8'd17 || sectors_per_track == 8'd31
               || sectors_per_track == 8'd63 || sectors_per_track == 8'd255)
    else $error("illegal sectors per track");

  // Only the 17-sector geometry may use fewer than 16 heads.
  a_heads_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> head_count >= 5'd4 && head_count <= 5'd16
               && (sectors_per_track == 8'd17 || head_count == 5'd16))
    else $error("head count out of range for the chosen sectors per track");

endmodule

bind disk_chs_geometry_core dcg_checker u_dcg_checker (.*);
